// ----- src/dcf_pkg.sv -----
// Package for the dense Cholesky factor core: payload types and fixed constants.
// No dependencies.
package dcf_pkg;
	localparam int ELEM_W = 32;
	localparam int CFG_W = 17;
	localparam logic CFG_DIM = 1'b0;
	localparam logic CFG_FLOOR = 1'b1;

	typedef struct packed {
		logic [2:0] elem_row;
		logic [2:0] elem_col;
		logic signed [31:0] elem_value;
		logic last_elem;
	} in_word_t;

	typedef struct packed {
		logic [2:0] l_row;
		logic [2:0] l_col;
		logic signed [31:0] l_value;
		logic pivot_clamped;
		logic last_result;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic acc_init;
		logic acc_sub;
		logic root_go;
		logic div_go;
		logic wr_l;
	} dp_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
	} dp_stat_t;
endpackage

// ----- src/dcf_datapath.sv -----
// Datapath of the dense Cholesky factor core: triangle store, multiply-subtract
// accumulator, bit-serial square root and divider. Depends on dcf_pkg.
module dcf_datapath #(
	parameter int MAX_DIM = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic ld_we,
	input  logic [5:0] ld_addr,
	input  logic signed [31:0] ld_data,
	input  logic [5:0] rd_addr,
	input  logic [5:0] wr_addr,
	input  logic [16:0] floor_val,
	input  dcf_pkg::dp_cmd_t cmd,
	output dcf_pkg::dp_stat_t stat,
	output logic signed [31:0] rd_data,
	output logic signed [31:0] l_val,
	output logic clamped
);
	import dcf_pkg::*;
	localparam int DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] a_q, b_q;
	logic signed [63:0] prod_q, acc_q, diff;
	logic [63:0] rx_q, rres_q, rbit_q, rsum;
	logic signed [63:0] drem_q;
	logic [63:0] dquo_q, dden_q;
	logic [6:0] dcnt_q;
	logic dneg_q, ract_q, dact_q, phase_q;
	logic [63:0] dabs, dtry;

	always_ff @(posedge clk) begin
		if (ld_we)
			mem[ld_addr[$clog2(DEPTH)-1:0]] <= ld_data;
		else if (cmd.wr_l)
			mem[wr_addr[$clog2(DEPTH)-1:0]] <= l_val;
		rd_data <= mem[rd_addr[$clog2(DEPTH)-1:0]];
	end

	// rd_data alternates between the two operands of one product
	always_ff @(posedge clk) begin
		if (cmd.acc_sub) begin
			phase_q <= ~phase_q;
			if (!phase_q) a_q <= rd_data;
			else prod_q <= a_q * rd_data;
		end else phase_q <= 1'b0;
	end

	always_comb begin
		diff = acc_q - prod_q;
		if (!prod_q[63] && prod_q != 0 && acc_q[63] && !diff[63]) diff = {1'b1, 63'd0};
		else if (prod_q[63] && !acc_q[63] && diff[63]) diff = {1'b0, {63{1'b1}}};
	end

	logic sub_pend_q;
	always_ff @(posedge clk) begin
		sub_pend_q <= cmd.acc_sub && phase_q;
		if (cmd.acc_init)
			acc_q <= 64'(signed'(rd_data)) <<< FRAC_BITS;
		else if (sub_pend_q)
			acc_q <= diff;
	end

	assign rsum = rres_q + rbit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ract_q <= 1'b0;
			dact_q <= 1'b0;
		end else begin
			if (cmd.root_go) begin
				ract_q <= 1'b1;
				clamped <= (acc_q <= 0);
				rx_q <= (acc_q <= 0) ? (64'(floor_val) << FRAC_BITS) : acc_q;
				rres_q <= '0;
				rbit_q <= 64'd1 << 62;
			end else if (ract_q) begin
				if (rbit_q == 0) ract_q <= 1'b0;
				else begin
					if (rx_q >= rsum) begin
						rx_q <= rx_q - rsum;
						rres_q <= (rres_q >> 1) + rbit_q;
					end else rres_q <= rres_q >> 1;
					rbit_q <= rbit_q >> 2;
				end
			end
			if (cmd.div_go) begin
				dact_q <= 1'b1;
				clamped <= 1'b0;
				dneg_q <= acc_q[63];
				drem_q <= '0;
				dquo_q <= acc_q[63] ? 64'(-acc_q) : acc_q;
				dden_q <= (rd_data < 1) ? 64'd1 : 64'(rd_data);
				dcnt_q <= 7'd64;
			end else if (dact_q) begin
				if (dcnt_q == 0) dact_q <= 1'b0;
				else begin
					dcnt_q <= dcnt_q - 7'd1;
					if (dtry >= dden_q) begin
						drem_q <= signed'(dtry - dden_q);
						dquo_q <= {dquo_q[62:0], 1'b1};
					end else begin
						drem_q <= signed'(dtry);
						dquo_q <= {dquo_q[62:0], 1'b0};
					end
				end
			end
		end
	end
	assign dtry = {drem_q[62:0], dquo_q[63]};
	assign dabs = dquo_q;

	assign stat.root_done = ract_q && rbit_q == 0;
	assign stat.div_done = dact_q && dcnt_q == 0;

	always_comb begin
		if (ract_q)
			l_val = (rres_q > 64'h7fffffff) ? 32'sh7fffffff : signed'(rres_q[31:0]);
		else if (!dneg_q)
			l_val = (dabs > 64'h7fffffff) ? 32'sh7fffffff : signed'(dabs[31:0]);
		else
			l_val = (dabs > 64'h80000000) ? 32'sh80000000 : signed'(32'(-dabs));
	end
endmodule

// ----- src/dcf_ctrl.sv -----
// Sequencer of the dense Cholesky factor core: walks rows, columns and the
// inner product index, steering the datapath. Depends on dcf_pkg.
module dcf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [3:0] dim,
	input  dcf_pkg::dp_stat_t stat,
	output dcf_pkg::dp_cmd_t cmd,
	output logic [5:0] rd_addr,
	output logic [5:0] wr_addr,
	output logic busy,
	output logic [2:0] cur_i,
	output logic [2:0] cur_j,
	output logic emit,
	output logic last
);
	import dcf_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0, S_RDA = 3'd1, S_INIT = 3'd2, S_SUB = 3'd3,
		S_DRAIN = 3'd4, S_OP = 3'd5, S_WAIT = 3'd6;
	logic [2:0] state_q, i_q, j_q, k_q;
	logic ph_q;
	logic [1:0] dr_q;

	function automatic logic [5:0] tri_pos(input logic [2:0] r, input logic [2:0] c);
		return 6'((r * (r + 4'd1)) >> 1) + 6'(c);
	endfunction

	assign busy = state_q != S_IDLE;
	assign cur_i = i_q;
	assign cur_j = j_q;
	assign wr_addr = tri_pos(i_q, j_q);
	assign emit = cmd.wr_l;
	assign last = (4'(i_q) + 4'd1 == dim) && (i_q == j_q);

	always_comb begin
		cmd = '0;
		rd_addr = tri_pos(i_q, j_q);
		case (state_q)
			S_INIT: cmd.acc_init = 1'b1;
			S_SUB: begin
				cmd.acc_sub = 1'b1;
				// read L(j,k) now for the product, then L(i,k+1) for the next one
				rd_addr = ph_q ? tri_pos(i_q, k_q + 3'd1) : tri_pos(j_q, k_q);
			end
			S_DRAIN: rd_addr = tri_pos(j_q, j_q);
			S_OP: begin
				cmd.root_go = (i_q == j_q);
				cmd.div_go = (i_q != j_q);
			end
			S_WAIT: cmd.wr_l = stat.root_done || stat.div_done;
			default: ;
		endcase
		if (state_q == S_INIT) rd_addr = tri_pos(i_q, 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= 1'b0; dr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (go) begin
					i_q <= '0; j_q <= '0;
					state_q <= S_RDA;
				end
				S_RDA: state_q <= S_INIT;
				S_INIT: begin
					k_q <= '0; ph_q <= 1'b0;
					state_q <= (j_q == 0) ? S_DRAIN : S_SUB;
					dr_q <= '0;
				end
				S_SUB: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (k_q + 3'd1 == j_q) state_q <= S_DRAIN;
						else k_q <= k_q + 3'd1;
					end
				end
				S_DRAIN: begin
					dr_q <= dr_q + 2'd1;
					if (dr_q == 2'd2) state_q <= S_OP;
				end
				S_OP: state_q <= S_WAIT;
				S_WAIT: if (stat.root_done || stat.div_done) begin
					if (last) state_q <= S_IDLE;
					else begin
						state_q <= S_RDA;
						if (j_q == i_q) begin
							i_q <= i_q + 3'd1; j_q <= '0;
						end else j_q <= j_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/dense_cholesky_factor_core.sv -----
// Dense Cholesky factor core, top level: config registers, sequencer and
// datapath. Depends on dcf_pkg, dcf_ctrl, dcf_datapath.
//
// Use: write matrix_dim (index 0) and pivot_floor (index 1) while idle. Load the
// lower triangle one word per cycle with start high while busy is low; a
// column above the row is swapped, a row at or beyond the size is dropped.
// The word with last_elem set raises busy and the factor is computed row by
// row. Each L word appears on result for one cycle with result_valid high,
// in row order; last_result marks the final one, and busy falls as it appears.
// Each L element is then formed from reads and multiply-subtract, followed by
// a bit-serial unit: the square root (two bits per cycle) or the divider
// (one bit per cycle). The receiver cannot stall; results are simply shown.
// Reset sets the sequencer idle, matrix_dim to 8 and pivot_floor to 1; the
// matrix store is undefined until loaded.
module dense_cholesky_factor_core #(
	parameter int MAX_DIM = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  dcf_pkg::in_word_t item,
	output logic result_valid,
	output dcf_pkg::out_word_t result,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [16:0] cfg_data
);
	import dcf_pkg::*;
	logic [3:0] dim_q, dim;
	logic [16:0] floor_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [5:0] rd_addr, wr_addr, ld_addr;
	logic signed [31:0] rd_data, l_val;
	logic clamped, emit, last, acc, ld_we;
	logic [2:0] r, c, ci, cj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= 4'd8;
			floor_q <= 17'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_DIM) dim_q <= cfg_data[3:0];
			else floor_q <= cfg_data;
		end
	end
	assign dim = (dim_q == 0) ? 4'd1 : (dim_q > 4'(MAX_DIM)) ? 4'(MAX_DIM) : dim_q;

	assign acc = start && !busy;
	assign r = (item.elem_col > item.elem_row) ? item.elem_col : item.elem_row;
	assign c = (item.elem_col > item.elem_row) ? item.elem_row : item.elem_col;
	assign ld_addr = 6'((r * (r + 4'd1)) >> 1) + 6'(c);
	assign ld_we = acc && (4'(r) < dim);

	dcf_ctrl u_ctrl (.clk, .arst_n, .go(acc && item.last_elem), .dim, .stat, .cmd,
		.rd_addr, .wr_addr, .busy, .cur_i(ci), .cur_j(cj), .emit, .last);

	dcf_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (.clk, .arst_n, .ld_we,
		.ld_addr, .ld_data(item.elem_value), .rd_addr, .wr_addr, .floor_val(floor_q),
		.cmd, .stat, .rd_data, .l_val, .clamped);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= emit;
	end
	always_ff @(posedge clk) begin
		if (emit) result <= '{l_row: ci, l_col: cj, l_value: l_val,
			pivot_clamped: clamped, last_result: last};
	end
endmodule

// ----- src/dcf_checker.sv -----
// Port checker for the dense Cholesky factor core, bound to the top level.
// Depends on dcf_pkg.
module dcf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input dcf_pkg::in_word_t item,
	input logic result_valid,
	input dcf_pkg::out_word_t result
);
	a_last_rises_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.last_elem |=> busy) else $error("busy not raised");
	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> busy) else $error("stray result");
	a_col_le_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.l_col <= result.l_row) else $error("bad position");
	a_clamp_diag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pivot_clamped |-> result.l_col == result.l_row)
		else $error("clamp off diagonal");
endmodule

bind dense_cholesky_factor_core dcf_checker u_chk (.clk, .arst_n, .start, .busy, .item,
	.result_valid, .result);
